FILE: sv/central_difference_gradient_defines.svh
// Assertion macros shared by the gradient block's modules.
`ifndef CENTRAL_DIFFERENCE_GRADIENT_DEFINES_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CDG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: sv/cdg_pkg.sv
// Shared constants and types of the central-difference gradient block.
`default_nettype none

package cdg_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	localparam int ROW_W      = 12;
	localparam int OUT_COL_W  = 10;
	localparam int WIDTH_CFG_W  = 11;
	localparam int HEIGHT_CFG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;

	localparam int MIN_DIM      = 3;
	localparam int MAX_HEIGHT   = 4096;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Result slots of one word, in delivery order.
	localparam int RES_UPPER       = 0;  // row r-1, column c-1
	localparam int RES_UPPER_LAST  = 1;  // row r-1, last column
	localparam int RES_BOTTOM      = 2;  // bottom row, column c-1
	localparam int RES_BOTTOM_LAST = 3;  // bottom row, last column
	localparam int RES_SLOTS       = 4;

	typedef struct packed {
		logic [RES_SLOTS-1:0] mask;
		logic [ROW_W-1:0]     row;
	} job_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/cdg_front.sv
// Front end: pixel intake, raster counters, line store and gradient arithmetic.
`default_nettype none

`include "central_difference_gradient_defines.svh"

module cdg_front import cdg_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int GW    = PIXEL_BITS + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [CFG_INDEX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         push,
	input  logic [PIXEL_BITS-1:0]        pixel,
	output logic                         full,
	input  logic                         q_full,
	output logic                         q_push,
	output job_ctrl_t                    q_ctrl,
	output logic [COL_W-1:0]             q_col,
	output logic [RES_SLOTS*GW-1:0]      q_grad
);

	localparam int WIDTH_RESET_CL = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam logic [COL_W-1:0] LAST_COL_RESET = COL_W'(WIDTH_RESET_CL - 1);
	localparam logic [ROW_W-1:0] LAST_ROW_RESET = ROW_W'(HEIGHT_RESET - 1);

	logic [COL_W-1:0] col_q, last_col_q;
	logic [ROW_W-1:0] row_q, last_row_q;

	logic                    s1_v;
	logic [PIXEL_BITS-1:0]   pix_s1;
	logic [COL_W-1:0]        col_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [2*PIXEL_BITS-1:0] rd_s1;

	logic [PIXEL_BITS-1:0] aw0_q, aw1_q, t_q, hist0_q, hist1_q;
	logic                    pend_v_q;
	logic [2*PIXEL_BITS-1:0] pend_data_q;
	logic [COL_W-1:0]        pend_col_q;

	// Each word holds {line above, line two above} of one column.
	logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];

	logic accept, s1_adv;
	logic [PIXEL_BITS-1:0] a_cur, t_cur;
	logic c_ge1, c_ge2, is_lastc, r_ge1, r_ge2, is_lastr;
	logic [RES_SLOTS-1:0] mask;
	logic signed [GW-1:0] gx_a, gy_a, gy_b, gx_c;
	logic                    wr_en;
	logic [COL_W-1:0]        wr_addr;
	logic [2*PIXEL_BITS-1:0] wr_data;
	logic [WIDTH_CFG_W-1:0]  wv;
	logic [HEIGHT_CFG_W-1:0] hv;
	logic [COL_W-1:0]        last_col_new;
	logic [ROW_W-1:0]        last_row_new;

	assign a_cur = rd_s1[2*PIXEL_BITS-1:PIXEL_BITS];
	assign t_cur = rd_s1[PIXEL_BITS-1:0];

	assign c_ge1    = col_s1 != '0;
	assign c_ge2    = col_s1 > COL_W'(1);
	assign is_lastc = col_s1 == last_col_q;
	assign r_ge1    = row_s1 != '0;
	assign r_ge2    = row_s1 > ROW_W'(1);
	assign is_lastr = row_s1 == last_row_q;

	always_comb begin
		mask = '0;
		mask[RES_UPPER]       = r_ge1 & c_ge1;
		mask[RES_UPPER_LAST]  = r_ge1 & is_lastc;
		mask[RES_BOTTOM]      = is_lastr & c_ge1;
		mask[RES_BOTTOM_LAST] = is_lastr & is_lastc;
	end

	assign gx_a = c_ge2 ? ($signed({1'b0, a_cur}) - $signed({1'b0, aw1_q})) : '0;
	assign gy_a = r_ge2 ? ($signed({1'b0, hist0_q}) - $signed({1'b0, t_q})) : '0;
	assign gy_b = r_ge2 ? ($signed({1'b0, pix_s1}) - $signed({1'b0, t_cur})) : '0;
	assign gx_c = c_ge2 ? ($signed({1'b0, pix_s1}) - $signed({1'b0, hist1_q})) : '0;

	// Words with no result still pass to keep the history moving.
	assign s1_adv = s1_v & ((mask == '0) | ~q_full);
	assign full   = s1_v & ~s1_adv;
	assign accept = push & ~full;

	assign q_push        = s1_adv & (mask != '0);
	assign q_ctrl.mask   = mask;
	assign q_ctrl.row    = row_s1;
	assign q_col         = col_s1;
	assign q_grad        = {gx_c, gy_b, gy_a, gx_a};

	// Column c-1 is stored one step late; the last column waits for the next column 0.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = col_s1 - COL_W'(1);
		wr_data = {hist0_q, aw0_q};
		if (s1_adv) begin
			if (c_ge1) begin
				wr_en = 1'b1;
			end else if (pend_v_q) begin
				wr_en   = 1'b1;
				wr_addr = pend_col_q;
				wr_data = pend_data_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[col_q];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		wv = cfg_data[WIDTH_CFG_W-1:0];
		hv = cfg_data[HEIGHT_CFG_W-1:0];
		if (wv < WIDTH_CFG_W'(MIN_DIM)) begin
			last_col_new = COL_W'(MIN_DIM - 1);
		end else if (32'(wv) > 32'(MAX_WIDTH)) begin
			last_col_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col_new = COL_W'(wv - WIDTH_CFG_W'(1));
		end
		if (hv < HEIGHT_CFG_W'(MIN_DIM)) begin
			last_row_new = ROW_W'(MIN_DIM - 1);
		end else if (hv > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
			last_row_new = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			last_row_new = ROW_W'(hv - HEIGHT_CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			last_col_q <= LAST_COL_RESET;
			last_row_q <= LAST_ROW_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					last_col_q <= last_col_new;
					col_q      <= '0;
					row_q      <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					last_row_q <= last_row_new;
					col_q      <= '0;
					row_q      <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v     <= 1'b0;
			pend_v_q <= 1'b0;
			aw0_q    <= '0;
			aw1_q    <= '0;
			t_q      <= '0;
			hist0_q  <= '0;
			hist1_q  <= '0;
		end else begin
			if (accept) begin
				s1_v <= 1'b1;
			end else if (s1_adv) begin
				s1_v <= 1'b0;
			end
			if (s1_adv) begin
				aw1_q   <= aw0_q;
				aw0_q   <= a_cur;
				t_q     <= t_cur;
				hist1_q <= hist0_q;
				hist0_q <= pix_s1;
				if (!c_ge1) begin
					pend_v_q <= 1'b0;
				end
				if (is_lastc) begin
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
		if (s1_adv && is_lastc) begin
			pend_data_q <= {pix_s1, a_cur};
			pend_col_q  <= col_s1;
		end
	end

	`CDG_ASSERT_NOW(a_front_no_push_when_full, clk, arst_n, q_push, !q_full)
	`CDG_ASSERT_NEXT(a_front_col_wrap, clk, arst_n,
		accept && !cfg_write && col_q == last_col_q, col_q == '0)

endmodule

`default_nettype wire

FILE: sv/cdg_back.sv
// Back end: word queue and expansion of each word into its result words.
`default_nettype none

`include "central_difference_gradient_defines.svh"

module cdg_back import cdg_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int GW    = PIXEL_BITS + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_push,
	input  job_ctrl_t                    q_ctrl,
	input  logic [COL_W-1:0]             q_col,
	input  logic [RES_SLOTS*GW-1:0]      q_grad,
	output logic                         q_full,
	input  logic                         pop,
	output logic                         empty,
	output logic signed [GW-1:0]         grad_x,
	output logic signed [GW-1:0]         grad_y,
	output logic [ROW_W-1:0]             out_row,
	output logic [OUT_COL_W-1:0]         out_col,
	output logic                         last_in_run
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		job_ctrl_t               ctrl;
		logic [COL_W-1:0]        col;
		logic [RES_SLOTS*GW-1:0] grad;
	} job_t;

	job_t             jobs_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [RES_SLOTS-1:0] done_q;

	job_t                 head;
	logic [RES_SLOTS-1:0] remaining, sel;
	logic                 deq, take;
	logic signed [GW-1:0] gx_a, gy_a, gy_b, gx_c;
	logic [COL_W-1:0]     col_out;

	assign head      = jobs_q[rd_ptr_q];
	assign empty     = count_q == '0;
	assign q_full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign remaining = head.ctrl.mask & ~done_q;
	assign sel       = remaining & (~remaining + RES_SLOTS'(1));
	assign last_in_run = (remaining & ~sel) == '0;

	assign take = pop & ~empty;
	assign deq  = take & last_in_run;

	assign {gx_c, gy_b, gy_a, gx_a} = head.grad;

	always_comb begin
		grad_x = '0;
		grad_y = '0;
		if (sel[RES_UPPER]) begin
			grad_x = gx_a;
			grad_y = gy_a;
		end else if (sel[RES_UPPER_LAST]) begin
			grad_y = gy_b;
		end else if (sel[RES_BOTTOM]) begin
			grad_x = gx_c;
		end
	end

	assign out_row = (sel[RES_UPPER] | sel[RES_UPPER_LAST]) ?
		head.ctrl.row - ROW_W'(1) : head.ctrl.row;
	assign col_out = (sel[RES_UPPER] | sel[RES_BOTTOM]) ?
		head.col - COL_W'(1) : head.col;
	assign out_col = OUT_COL_W'(col_out);

	always_ff @(posedge clk) begin
		if (q_push) begin
			jobs_q[wr_ptr_q] <= '{ctrl: q_ctrl, col: q_col, grad: q_grad};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			done_q   <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
				done_q   <= '0;
			end else if (take) begin
				done_q <= done_q | sel;
			end
			case ({q_push, deq})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`CDG_ASSERT_NOW(a_back_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`CDG_ASSERT_NOW(a_back_head_has_work, clk, arst_n, !empty, remaining != '0)
	`CDG_ASSERT_NEXT(a_back_partial_pop_holds, clk, arst_n, take && !last_in_run, !empty)

endmodule

`default_nettype wire

FILE: sv/central_difference_gradient.sv
// Top level of the central-difference gradient block.
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  ------------------------------------------
//  pixel    in         push / full        pixel
//  result   out        pop / empty        grad_x, grad_y, out_row, out_col, last_in_run
//  config   in         cfg_write          cfg_index, cfg_data
//
// One pixel a cycle is taken unless full; each pixel yields zero to four result words,
// one word leaving per cycle on pop from a four-word queue between front and back end.
// A pixel's result words reach the result ports through the front stage and the queue:
// line store read into the front stage, arithmetic into the queue, queue head to ports.
// full rises only when the queue is full and the front stage holds a word with results.
// Reset (arst_n low) empties the pipeline and queue, zeroes the raster counters and
// loads a 640 by 480 frame; line store contents are undefined until written.
`default_nettype none

module central_difference_gradient import cdg_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [CFG_INDEX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic [PIXEL_BITS-1:0]        pixel,
	input  logic                         pop,
	output logic                         empty,
	output logic signed [PIXEL_BITS:0]   grad_x,
	output logic signed [PIXEL_BITS:0]   grad_y,
	output logic [ROW_W-1:0]             out_row,
	output logic [OUT_COL_W-1:0]         out_col,
	output logic                         last_in_run
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int GW    = PIXEL_BITS + 1;

	logic                    q_full, q_push;
	job_ctrl_t               q_ctrl;
	logic [COL_W-1:0]        q_col;
	logic [RES_SLOTS*GW-1:0] q_grad;

	cdg_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_ctrl    (q_ctrl),
		.q_col     (q_col),
		.q_grad    (q_grad)
	);

	cdg_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_push      (q_push),
		.q_ctrl      (q_ctrl),
		.q_col       (q_col),
		.q_grad      (q_grad),
		.q_full      (q_full),
		.pop         (pop),
		.empty       (empty),
		.grad_x      (grad_x),
		.grad_y      (grad_y),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_in_run (last_in_run)
	);

endmodule

`default_nettype wire
